[rtl/acc_pkg.sv]
package acc_pkg;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	typedef struct packed {
		logic [3:0] thousands;
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	localparam int unsigned HIST_W = 13;
	localparam logic [HIST_W-1:0] HIST_PRESS = 13'h1000;
	localparam logic [10:0] FREQ_LOW = 11'd871;
	localparam logic [10:0] FREQ_HIGH = 11'd1079;
	localparam logic [10:0] FREQ_RESET = 11'd887;
	localparam logic [3:0] VOLUME_RESET = 4'd5;
	localparam logic [3:0] VOLUME_MAX = 4'd15;
	localparam logic [5:0] SNOOZE_LONG = 6'd60;
	localparam logic [5:0] SNOOZE_SHORT = 6'd10;
	localparam tod_t CLOCK_RESET = '{hour: 5'd0, minute: 6'd59, second: 6'd50};
	localparam tod_t ALARM_RESET = '{hour: 5'd1, minute: 6'd0, second: 6'd0};

	localparam logic [3:0] MSG_NONE = 4'd0;
	localparam logic [3:0] MSG_SET_ALARM = 4'd1;
	localparam logic [3:0] MSG_NORMAL = 4'd2;
	localparam logic [3:0] MSG_SET_TIME = 4'd3;
	localparam logic [3:0] MSG_ALARM_RADIO = 4'd4;
	localparam logic [3:0] MSG_ALARM_TONE = 4'd5;
	localparam logic [3:0] MSG_ALARM_OFF = 4'd6;
	localparam logic [3:0] MSG_ALARM_ON = 4'd7;
	localparam logic [3:0] MSG_SNOOZE_ON = 4'd8;
	localparam logic [3:0] MSG_SNOOZE_NA = 4'd9;
	localparam logic [3:0] MSG_SNOOZE_1MIN = 4'd10;
	localparam logic [3:0] MSG_SNOOZE_10S = 4'd11;
	localparam logic [3:0] MSG_RADIO_ON = 4'd12;
	localparam logic [3:0] MSG_RADIO_OFF = 4'd13;
	localparam logic [3:0] MSG_12H = 4'd14;
	localparam logic [3:0] MSG_24H = 4'd15;

	function automatic tod_t hour_inc(tod_t t);
		tod_t r;
		r = t;
		r.hour = (t.hour == 5'd23) ? 5'd0 : t.hour + 5'd1;
		return r;
	endfunction

	function automatic tod_t hour_dec(tod_t t);
		tod_t r;
		r = t;
		r.hour = (t.hour == 5'd0) ? 5'd23 : t.hour - 5'd1;
		return r;
	endfunction

	function automatic tod_t min_inc(tod_t t);
		tod_t r;
		r = t;
		if (t.minute == 6'd59) begin
			r.minute = 6'd0;
			r = hour_inc(r);
		end else begin
			r.minute = t.minute + 6'd1;
		end
		return r;
	endfunction

	function automatic tod_t min_dec(tod_t t);
		tod_t r;
		r = t;
		if (t.minute == 6'd0) begin
			r.minute = 6'd59;
			r = hour_dec(r);
		end else begin
			r.minute = t.minute - 6'd1;
		end
		return r;
	endfunction

	function automatic tod_t sec_inc(tod_t t);
		tod_t r;
		r = t;
		if (t.second == 6'd59) begin
			r.second = 6'd0;
			r = min_inc(r);
		end else begin
			r.second = t.second + 6'd1;
		end
		return r;
	endfunction

endpackage

[rtl/acc_debounce.sv]
module acc_debounce #(
	parameter int BUTTON_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] levels,
	output logic [7:0] pressed
);
	for (genvar i = 0; i < 8; i++) begin : g_btn
		if (i < BUTTON_COUNT) begin : g_live
			logic [acc_pkg::HIST_W-1:0] hist_q;
			logic [acc_pkg::HIST_W-1:0] hist_d;
			assign hist_d = {hist_q[acc_pkg::HIST_W-2:0], levels[i]};
			assign pressed[i] = en && (hist_d == acc_pkg::HIST_PRESS);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					hist_q <= '0;
				end else if (en) begin
					hist_q <= hist_d;
				end
			end
		end else begin : g_absent
			assign pressed[i] = 1'b0;
		end
	end
endmodule

[rtl/acc_display.sv]
module acc_display (
	input  logic             freq_shown,
	input  logic             set_alarm,
	input  logic             twelve,
	input  logic [10:0]      freq,
	input  acc_pkg::tod_t    clock_tod,
	input  acc_pkg::tod_t    alarm_tod,
	output acc_pkg::digits_t digits
);
	// Split 0..99 into tens and ones by reciprocal multiply.
	function automatic logic [7:0] split99(logic [6:0] v);
		logic [13:0] p;
		logic [3:0] t;
		logic [6:0] o;
		p = v * 7'd103;
		t = p[13:10];
		o = v - 7'(t) * 7'd10;
		return {t, o[3:0]};
	endfunction

	acc_pkg::tod_t src;
	logic [4:0] hr;
	logic [7:0] hd, md, fd;
	logic       f_th;
	logic [9:0] f_rem;
	logic [21:0] f_prod;
	logic [3:0] f_hu;
	logic [9:0] f_low;
	acc_pkg::digits_t raw;

	always_comb begin
		src = set_alarm ? alarm_tod : clock_tod;
		hr = (twelve && src.hour >= 5'd12) ? src.hour - 5'd12 : src.hour;
		hd = split99({2'b00, hr});
		md = split99({1'b0, src.minute});
		f_th = (freq >= 11'd1000);
		f_rem = f_th ? 10'(freq - 11'd1000) : freq[9:0];
		f_prod = f_rem * 12'd41;
		f_hu = f_prod[15:12];
		f_low = f_rem - 10'(f_hu) * 10'd100;
		fd = split99(f_low[6:0]);
		if (freq_shown) begin
			raw = '{thousands: {3'b000, f_th}, hundreds: f_hu, tens: fd[7:4], ones: fd[3:0]};
		end else begin
			raw = '{thousands: hd[7:4], hundreds: hd[3:0], tens: md[7:4], ones: md[3:0]};
		end
		digits = raw;
		// Show a leading 00 as 12 in twelve hour mode
		if (twelve && raw.thousands == 4'd0 && raw.hundreds == 4'd0) begin
			digits.thousands = 4'd1;
			digits.hundreds = 4'd2;
		end
	end
endmodule

[rtl/alarm_clock_controller.sv]
// Alarm clock controller. Each accepted input word is one timer tick carrying raw button
// levels and two quadrature knob pairs; each tick yields exactly one output word with the
// four display digits, colon, tone and radio state, tuned frequency, volume, a status
// message and a radio command strobe. Buttons debounce over a 13-sample history, the
// seconds-of-day clock advances every TICKS_PER_SECOND ticks, and time is held as
// hour/minute/second fields so the display needs no divider. A tick enters an input
// register, passes one layer of state-update and digit logic, and lands in the output
// register once that register is empty or being read out, and one word per cycle is
// sustained while out_ready stays high. While a finished result waits on out_ready the
// input register takes one more word, then in_ready drops until the result leaves.
module alarm_clock_controller #(
	parameter int TICKS_PER_SECOND = 128,
	parameter int BUTTON_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  button_levels,
	input  logic [3:0]  knob_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  digit_thousands,
	output logic [3:0]  digit_hundreds,
	output logic [3:0]  digit_tens,
	output logic [3:0]  digit_ones,
	output logic        colon_lit,
	output logic        tone_sounding,
	output logic        radio_enabled,
	output logic [10:0] tuned_frequency,
	output logic [3:0]  volume_level,
	output logic [3:0]  status_message,
	output logic        radio_command
);
	localparam int TW = $clog2(TICKS_PER_SECOND + 1);
	localparam logic [TW-1:0] TICK_HALF = TW'(TICKS_PER_SECOND / 2);
	localparam logic [TW-1:0] TICK_FULL = TW'(TICKS_PER_SECOND);

	// Input register
	logic       v_s1;
	logic [7:0] levels_s1;
	logic [3:0] knobs_s1;
	logic       adv;

	assign adv = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			levels_s1 <= button_levels;
			knobs_s1 <= knob_bits;
		end
	end

	// State
	logic [TW-1:0] tick_q, tick_d;
	acc_pkg::tod_t clock_q, clock_d, alarm_q, alarm_d;
	logic set_time_q, set_time_d, set_alarm_q, set_alarm_d;
	logic set_volume_q, set_volume_d, set_radio_q, set_radio_d;
	logic radio_on_q, radio_on_d, alarm_radio_q, alarm_radio_d;
	logic twelve_q, twelve_d, armed_q, armed_d, colon_q, colon_d;
	logic [5:0] snooze_q, snooze_d;
	logic [3:0] volume_q, volume_d;
	logic [10:0] freq_q, freq_d;
	logic [3:0] knob_prev_q;
	logic [1:0] fsc_q, fsc_d;
	logic playing_q, playing_d, shown_q, shown_d, long_q, long_d;
	logic tone_q, tone_d, live_q, live_d;
	logic [3:0] msg_d;
	logic cmd_d;
	logic [7:0] pressed;
	logic up1, dn1, up2, dn2;
	acc_pkg::digits_t digits;

	acc_debounce #(.BUTTON_COUNT(BUTTON_COUNT)) u_debounce (
		.clk(clk), .arst_n(arst_n), .en(adv), .levels(levels_s1), .pressed(pressed)
	);

	assign up1 = knobs_s1[1:0] == 2'b01 && knob_prev_q[1:0] == 2'b00;
	assign dn1 = knobs_s1[1:0] == 2'b11 && knob_prev_q[1:0] == 2'b10;
	assign up2 = knobs_s1[3:2] == 2'b01 && knob_prev_q[3:2] == 2'b00;
	assign dn2 = knobs_s1[3:2] == 2'b11 && knob_prev_q[3:2] == 2'b10;

	always_comb begin
		tick_d = tick_q; clock_d = clock_q; alarm_d = alarm_q;
		set_time_d = set_time_q; set_alarm_d = set_alarm_q;
		set_volume_d = set_volume_q; set_radio_d = set_radio_q;
		radio_on_d = radio_on_q; alarm_radio_d = alarm_radio_q;
		twelve_d = twelve_q; armed_d = armed_q; colon_d = colon_q;
		snooze_d = snooze_q; volume_d = volume_q; freq_d = freq_q; fsc_d = fsc_q;
		playing_d = playing_q; shown_d = shown_q; long_d = long_q;
		tone_d = tone_q; live_d = live_q;
		msg_d = acc_pkg::MSG_NONE; cmd_d = 1'b0;

		// Half second: drop the colon, age the frequency display
		if (tick_d == TICK_HALF) begin
			colon_d = 1'b0;
			if (fsc_d < 2'd2) fsc_d = fsc_d + 2'd1;
			if (fsc_d == 2'd2) shown_d = 1'b0;
		end
		// Full second: advance the clock and run the snooze down, restarting an armed alarm at zero
		if (tick_d == TICK_FULL) begin
			colon_d = 1'b1;
			tick_d = '0;
			clock_d = acc_pkg::sec_inc(clock_d);
			if (snooze_d != 6'd0) begin
				tone_d = 1'b0;
				snooze_d = snooze_d - 6'd1;
				if (snooze_d == 6'd0 && armed_d) begin
					if (!alarm_radio_d) begin
						live_d = 1'b0;
						tone_d = 1'b1;
					end else begin
						live_d = 1'b1;
					end
					playing_d = 1'b1;
					cmd_d = 1'b1;
				end
			end
		end
		tick_d = tick_d + TW'(1);
		if (set_alarm_d || set_time_d) colon_d = 1'b1;

		// Buttons, lowest first; the last message wins
		if (pressed[0] && !set_time_d && !shown_d) begin
			set_alarm_d = !set_alarm_d;
			set_volume_d = !set_alarm_d;
			set_radio_d = !set_alarm_d;
			msg_d = set_alarm_d ? acc_pkg::MSG_SET_ALARM : acc_pkg::MSG_NORMAL;
		end
		if (pressed[1] && !set_alarm_d && !shown_d) begin
			set_time_d = !set_time_d;
			set_volume_d = !set_time_d;
			set_radio_d = !set_time_d;
			msg_d = set_time_d ? acc_pkg::MSG_SET_TIME : acc_pkg::MSG_NORMAL;
		end
		if (pressed[2]) begin
			alarm_radio_d = !alarm_radio_d;
			msg_d = alarm_radio_d ? acc_pkg::MSG_ALARM_RADIO : acc_pkg::MSG_ALARM_TONE;
		end
		if (pressed[3] && !playing_d) begin
			if (armed_d) begin
				armed_d = 1'b0;
				msg_d = acc_pkg::MSG_ALARM_OFF;
				if (!alarm_radio_d) begin
					tone_d = 1'b0;
				end else begin
					live_d = 1'b0;
					radio_on_d = 1'b0;
					cmd_d = 1'b1;
				end
			end else begin
				armed_d = 1'b1;
				msg_d = acc_pkg::MSG_ALARM_ON;
			end
		end
		if (pressed[4]) begin
			if (playing_d && armed_d) begin
				playing_d = 1'b0;
				snooze_d = long_d ? acc_pkg::SNOOZE_LONG : acc_pkg::SNOOZE_SHORT;
				msg_d = acc_pkg::MSG_SNOOZE_ON;
			end else begin
				msg_d = acc_pkg::MSG_SNOOZE_NA;
			end
		end
		if (pressed[5]) begin
			long_d = !long_d;
			msg_d = long_d ? acc_pkg::MSG_SNOOZE_1MIN : acc_pkg::MSG_SNOOZE_10S;
		end
		if (pressed[6] && !playing_d) begin
			radio_on_d = !radio_on_d;
			live_d = radio_on_d;
			cmd_d = 1'b1;
			msg_d = radio_on_d ? acc_pkg::MSG_RADIO_ON : acc_pkg::MSG_RADIO_OFF;
		end
		if (pressed[7]) begin
			twelve_d = !twelve_d;
			msg_d = twelve_d ? acc_pkg::MSG_12H : acc_pkg::MSG_24H;
		end

		// Knob one: hours and volume
		if (up1) begin
			if (set_time_d) clock_d = acc_pkg::hour_inc(clock_d);
			if (set_alarm_d) alarm_d = acc_pkg::hour_inc(alarm_d);
			if (set_volume_d && volume_d < acc_pkg::VOLUME_MAX) volume_d = volume_d + 4'd1;
		end
		if (dn1) begin
			if (set_time_d) clock_d = acc_pkg::hour_dec(clock_d);
			if (set_alarm_d) alarm_d = acc_pkg::hour_dec(alarm_d);
			if (set_volume_d && volume_d != 4'd0) volume_d = volume_d - 4'd1;
		end
		// Knob two: minutes and tuning
		if (up2) begin
			if (set_time_d) clock_d = acc_pkg::min_inc(clock_d);
			if (set_alarm_d) alarm_d = acc_pkg::min_inc(alarm_d);
			if (set_radio_d) begin
				freq_d = (freq_d + 11'd2 > acc_pkg::FREQ_HIGH) ? acc_pkg::FREQ_LOW
					: freq_d + 11'd2;
				fsc_d = 2'd0;
				shown_d = 1'b1;
				live_d = radio_on_d;
				cmd_d = 1'b1;
			end
		end
		if (dn2) begin
			if (set_time_d) clock_d = acc_pkg::min_dec(clock_d);
			if (set_alarm_d) alarm_d = acc_pkg::min_dec(alarm_d);
			if (set_radio_d) begin
				freq_d = (freq_d < acc_pkg::FREQ_LOW + 11'd2) ? acc_pkg::FREQ_HIGH
					: freq_d - 11'd2;
				fsc_d = 2'd0;
				shown_d = 1'b1;
				live_d = radio_on_d;
				cmd_d = 1'b1;
			end
		end

		// Alarm match, checked every tick
		if (armed_d && clock_d == alarm_d) begin
			if (!alarm_radio_d) begin
				live_d = 1'b0;
				tone_d = 1'b1;
			end else begin
				live_d = 1'b1;
				radio_on_d = 1'b1;
			end
			playing_d = 1'b1;
			cmd_d = 1'b1;
		end
	end

	acc_display u_display (
		.freq_shown(shown_d), .set_alarm(set_alarm_d), .twelve(twelve_d), .freq(freq_d),
		.clock_tod(clock_d), .alarm_tod(alarm_d), .digits(digits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			clock_q <= acc_pkg::CLOCK_RESET;
			alarm_q <= acc_pkg::ALARM_RESET;
			set_time_q <= 1'b0; set_alarm_q <= 1'b0;
			set_volume_q <= 1'b1; set_radio_q <= 1'b1;
			radio_on_q <= 1'b0; alarm_radio_q <= 1'b0;
			twelve_q <= 1'b0; armed_q <= 1'b0; colon_q <= 1'b1;
			snooze_q <= '0;
			volume_q <= acc_pkg::VOLUME_RESET;
			freq_q <= acc_pkg::FREQ_RESET;
			knob_prev_q <= '0;
			fsc_q <= '0;
			playing_q <= 1'b0; shown_q <= 1'b0; long_q <= 1'b0;
			tone_q <= 1'b0; live_q <= 1'b0;
		end else if (adv) begin
			tick_q <= tick_d; clock_q <= clock_d; alarm_q <= alarm_d;
			set_time_q <= set_time_d; set_alarm_q <= set_alarm_d;
			set_volume_q <= set_volume_d; set_radio_q <= set_radio_d;
			radio_on_q <= radio_on_d; alarm_radio_q <= alarm_radio_d;
			twelve_q <= twelve_d; armed_q <= armed_d; colon_q <= colon_d;
			snooze_q <= snooze_d; volume_q <= volume_d; freq_q <= freq_d;
			knob_prev_q <= knobs_s1;
			fsc_q <= fsc_d;
			playing_q <= playing_d; shown_q <= shown_d; long_q <= long_d;
			tone_q <= tone_d; live_q <= live_d;
		end
	end

	// Result register: hold the word until out_ready takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			digit_thousands <= digits.thousands;
			digit_hundreds <= digits.hundreds;
			digit_tens <= digits.tens;
			digit_ones <= digits.ones;
			colon_lit <= colon_d;
			tone_sounding <= tone_d;
			radio_enabled <= live_d;
			tuned_frequency <= freq_d;
			volume_level <= volume_d;
			status_message <= msg_d;
			radio_command <= cmd_d;
		end
	end
endmodule

[bench/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TICKS_PER_SECOND = 128;
	localparam int DAY = 86400;
	localparam int RANDOM_TICKS = 1300;

	// one expected output word
	typedef struct packed {
		logic [3:0]  th;
		logic [3:0]  hu;
		logic [3:0]  te;
		logic [3:0]  on;
		logic        colon;
		logic        tone;
		logic        radio;
		logic [10:0] freq;
		logic [3:0]  vol;
		logic [3:0]  msg;
		logic        cmd;
	} tick_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  button_levels;
	logic [3:0]  knob_bits;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  digit_thousands;
	logic [3:0]  digit_hundreds;
	logic [3:0]  digit_tens;
	logic [3:0]  digit_ones;
	logic        colon_lit;
	logic        tone_sounding;
	logic        radio_enabled;
	logic [10:0] tuned_frequency;
	logic [3:0]  volume_level;
	logic [3:0]  status_message;
	logic        radio_command;

	alarm_clock_controller #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND),
		.BUTTON_COUNT(8)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_levels(button_levels),
		.knob_bits(knob_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digit_thousands(digit_thousands),
		.digit_hundreds(digit_hundreds),
		.digit_tens(digit_tens),
		.digit_ones(digit_ones),
		.colon_lit(colon_lit),
		.tone_sounding(tone_sounding),
		.radio_enabled(radio_enabled),
		.tuned_frequency(tuned_frequency),
		.volume_level(volume_level),
		.status_message(status_message),
		.radio_command(radio_command)
	);

	// clock: 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// expected words in order of acceptance
	tick_word_t pending_words[$];
	int errors = 0;
	int words_checked = 0;
	int ticks_sent = 0;
	int presses_seen = 0;
	int alarms_seen = 0;
	bit quiet = 1'b0;   // set for a stretch with no idling on either side

	// ---------------------------------------------------------------
	// Own model of the clock: times kept as seconds of the day, other state at the block's widths
	// ---------------------------------------------------------------
	logic [12:0] hist [8];
	int unsigned ticks_in_sec;
	int unsigned clock_s;
	int unsigned alarm_s;
	bit set_time, set_alarm, set_volume, set_radio, radio_on;
	bit alarm_radio, twelve, armed, colon;
	logic [5:0]  snooze_cnt;
	logic [3:0]  vol_q;
	logic [10:0] freq_q;
	logic [3:0]  knob_q;
	logic [1:0]  show_cnt;
	bit playing, freq_shown, snooze_long, tone_on, radio_live;

	task automatic model_reset();
		foreach (hist[i]) hist[i] = '0;
		ticks_in_sec = 0;
		clock_s = 3590;
		alarm_s = 3600;
		{set_time, set_alarm, radio_on, alarm_radio, twelve, armed} = '0;
		set_volume = 1'b1;
		set_radio = 1'b1;
		colon = 1'b1;
		snooze_cnt = '0;
		vol_q = acc_pkg::VOLUME_RESET;
		freq_q = acc_pkg::FREQ_RESET;
		knob_q = '0;
		show_cnt = '0;
		{playing, freq_shown, snooze_long, tone_on, radio_live} = '0;
	endtask

	function automatic int unsigned day_step(int unsigned v, int d);
		return ((v % DAY) + DAY + d) % DAY;
	endfunction

	function automatic int unsigned hhmm(int unsigned s, bit twelve_h);
		int unsigned m;
		int unsigned h;
		m = (s % DAY) / 60;
		h = m / 60;
		return (m % 60) + 100 * (twelve_h ? (h % 12) : (h % 24));
	endfunction

	// advance the model by one tick and return the word it should produce
	function automatic tick_word_t predict_tick(logic [7:0] lv, logic [3:0] kn);
		tick_word_t w;
		logic [7:0] pressed;
		logic [3:0] msg;
		bit cmd;
		bit on;
		int unsigned disp;
		int unsigned th, hu;
		logic [1:0] k1, k2, o1, o2;
		msg = acc_pkg::MSG_NONE;
		cmd = 1'b0;
		pressed = '0;

		if (ticks_in_sec == TICKS_PER_SECOND / 2) begin
			colon = 1'b0;
			if (show_cnt < 2) show_cnt++;
			if (show_cnt == 2) freq_shown = 1'b0;
		end
		if (ticks_in_sec == TICKS_PER_SECOND) begin
			colon = 1'b1;
			ticks_in_sec = 0;
			clock_s = day_step(clock_s, 1);
			if (snooze_cnt > 0) begin
				tone_on = 1'b0;
				snooze_cnt--;
				if (snooze_cnt == 0 && armed) begin
					if (!alarm_radio) begin
						radio_live = 1'b0;
						tone_on = 1'b1;
					end else
						radio_live = 1'b1;
					playing = 1'b1;
					cmd = 1'b1;
				end
			end
		end
		ticks_in_sec++;
		if (set_alarm || set_time) colon = 1'b1;

		// sample every button before acting on any
		for (int i = 0; i < 8; i++) begin
			hist[i] = {hist[i][11:0], lv[i]};
			if (hist[i] == acc_pkg::HIST_PRESS) pressed[i] = 1'b1;
		end

		if (pressed[0] && !set_time && !freq_shown) begin
			on = !set_alarm;
			set_alarm = on;
			set_volume = !on;
			set_radio = !on;
			msg = on ? acc_pkg::MSG_SET_ALARM : acc_pkg::MSG_NORMAL;
		end
		if (pressed[1] && !set_alarm && !freq_shown) begin
			on = !set_time;
			set_time = on;
			set_volume = !on;
			set_radio = !on;
			msg = on ? acc_pkg::MSG_SET_TIME : acc_pkg::MSG_NORMAL;
		end
		if (pressed[2]) begin
			alarm_radio = !alarm_radio;
			msg = alarm_radio ? acc_pkg::MSG_ALARM_RADIO : acc_pkg::MSG_ALARM_TONE;
		end
		if (pressed[3] && !playing) begin
			if (armed) begin
				armed = 1'b0;
				msg = acc_pkg::MSG_ALARM_OFF;
				if (!alarm_radio)
					tone_on = 1'b0;
				else begin
					radio_live = 1'b0;
					radio_on = 1'b0;
					cmd = 1'b1;
				end
			end else begin
				armed = 1'b1;
				msg = acc_pkg::MSG_ALARM_ON;
			end
		end
		if (pressed[4]) begin
			if (playing && armed) begin
				playing = 1'b0;
				snooze_cnt = snooze_long ? acc_pkg::SNOOZE_LONG : acc_pkg::SNOOZE_SHORT;
				msg = acc_pkg::MSG_SNOOZE_ON;
			end else
				msg = acc_pkg::MSG_SNOOZE_NA;
		end
		if (pressed[5]) begin
			snooze_long = !snooze_long;
			msg = snooze_long ? acc_pkg::MSG_SNOOZE_1MIN : acc_pkg::MSG_SNOOZE_10S;
		end
		if (pressed[6] && !playing) begin
			radio_on = !radio_on;
			radio_live = radio_on;
			cmd = 1'b1;
			msg = radio_on ? acc_pkg::MSG_RADIO_ON : acc_pkg::MSG_RADIO_OFF;
		end
		if (pressed[7]) begin
			twelve = !twelve;
			msg = twelve ? acc_pkg::MSG_12H : acc_pkg::MSG_24H;
		end

		// only 00->01 counts as up and 10->11 as down
		k1 = kn[1:0];
		k2 = kn[3:2];
		o1 = knob_q[1:0];
		o2 = knob_q[3:2];
		if (k1 == 2'b01 && o1 == 2'b00) begin
			if (set_time) clock_s = day_step(clock_s, 3600);
			if (set_alarm) alarm_s = day_step(alarm_s, 3600);
			if (set_volume && vol_q < acc_pkg::VOLUME_MAX) vol_q++;
		end
		if (k1 == 2'b11 && o1 == 2'b10) begin
			if (set_time) clock_s = day_step(clock_s, -3600);
			if (set_alarm) alarm_s = day_step(alarm_s, -3600);
			if (set_volume && vol_q > 0) vol_q--;
		end
		if (k2 == 2'b01 && o2 == 2'b00) begin
			if (set_time) clock_s = day_step(clock_s, 60);
			if (set_alarm) alarm_s = day_step(alarm_s, 60);
			if (set_radio) begin
				freq_q = (freq_q + 11'd2 > acc_pkg::FREQ_HIGH) ? acc_pkg::FREQ_LOW
					: freq_q + 11'd2;
				show_cnt = '0;
				freq_shown = 1'b1;
				radio_live = radio_on;
				cmd = 1'b1;
			end
		end
		if (k2 == 2'b11 && o2 == 2'b10) begin
			if (set_time) clock_s = day_step(clock_s, -60);
			if (set_alarm) alarm_s = day_step(alarm_s, -60);
			if (set_radio) begin
				freq_q = (freq_q < acc_pkg::FREQ_LOW + 11'd2) ? acc_pkg::FREQ_HIGH
					: freq_q - 11'd2;
				show_cnt = '0;
				freq_shown = 1'b1;
				radio_live = radio_on;
				cmd = 1'b1;
			end
		end
		knob_q = kn;

		// alarm keeps firing for the whole matching second
		if (armed && clock_s == alarm_s) begin
			if (!alarm_radio) begin
				radio_live = 1'b0;
				tone_on = 1'b1;
			end else begin
				radio_live = 1'b1;
				radio_on = 1'b1;
			end
			playing = 1'b1;
			cmd = 1'b1;
		end

		if (freq_shown) disp = freq_q;
		else if (set_alarm) disp = hhmm(alarm_s, twelve);
		else disp = hhmm(clock_s, twelve);
		th = (disp / 1000) % 10;
		hu = (disp / 100) % 10;
		if (twelve && th == 0 && hu == 0) begin
			th = 1;
			hu = 2;
		end

		w.th = th[3:0];
		w.hu = hu[3:0];
		w.te = 4'((disp / 10) % 10);
		w.on = 4'(disp % 10);
		w.colon = colon;
		w.tone = tone_on;
		w.radio = radio_live;
		w.freq = freq_q;
		w.vol = vol_q;
		w.msg = msg;
		w.cmd = cmd;
		return w;
	endfunction

	// ---------------------------------------------------------------
	// Sending side
	// ---------------------------------------------------------------
	// Called at a falling edge; returns at the falling edge after acceptance,
	// with valid still high so the next word follows without a glitch.
	task automatic send_tick(logic [7:0] lv, logic [3:0] kn);
		while (!quiet && $urandom_range(99) < 26) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		button_levels = lv;
		knob_bits = kn;
		do
			@(posedge clk);
		while (!in_ready);
		begin : count_block
			tick_word_t w;
			w = predict_tick(lv, kn);
			if (w.msg != acc_pkg::MSG_NONE) presses_seen++;
			if (w.tone || (w.radio && playing)) alarms_seen++;
			pending_words.push_back(w);
		end
		ticks_sent++;
		@(negedge clk);
	endtask

	// hold off the sender until every expected word has come back
	task automatic drain_words();
		in_valid = 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
	endtask

	// one released tick, twelve ticks with the masked buttons held down, then one released tick
	task automatic press_buttons(logic [7:0] mask, logic [3:0] kn);
		send_tick(8'hFF, kn);
		repeat (12) send_tick(~mask, kn);
		send_tick(8'hFF, kn);
	endtask

	// one knob detent: pair 0 is knob one, pair 1 is knob two
	task automatic turn_knob(int pair, bit up);
		logic [3:0] a, b;
		a = '0;
		b = '0;
		if (pair == 0) begin
			a[1:0] = up ? 2'b00 : 2'b10;
			b[1:0] = up ? 2'b01 : 2'b11;
		end else begin
			a[3:2] = up ? 2'b00 : 2'b10;
			b[3:2] = up ? 2'b01 : 2'b11;
		end
		send_tick(8'hFF, a);
		send_tick(8'hFF, b);
	endtask

	// ---------------------------------------------------------------
	// Receiving side
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b1;
		else
			out_ready <= quiet || ($urandom_range(99) >= 26);
	end

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch word %0d %s: got %0d expected %0d",
			words_checked, field, got, want);
		errors++;
	endtask

	// compare each accepted output word with the oldest expectation
	always @(posedge clk) begin
		tick_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("unexpected output word at %0t", $realtime);
				errors++;
			end else begin
				w = pending_words.pop_front();
				if (digit_thousands !== w.th) report_mismatch("thousands", digit_thousands, w.th);
				if (digit_hundreds !== w.hu) report_mismatch("hundreds", digit_hundreds, w.hu);
				if (digit_tens !== w.te) report_mismatch("tens", digit_tens, w.te);
				if (digit_ones !== w.on) report_mismatch("ones", digit_ones, w.on);
				if (colon_lit !== w.colon) report_mismatch("colon", colon_lit, w.colon);
				if (tone_sounding !== w.tone) report_mismatch("tone", tone_sounding, w.tone);
				if (radio_enabled !== w.radio) report_mismatch("radio", radio_enabled, w.radio);
				if (tuned_frequency !== w.freq) report_mismatch("freq", tuned_frequency, w.freq);
				if (volume_level !== w.vol) report_mismatch("volume", volume_level, w.vol);
				if (status_message !== w.msg) report_mismatch("message", status_message, w.msg);
				if (radio_command !== w.cmd) report_mismatch("command", radio_command, w.cmd);
				words_checked++;
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// every button on its own, mostly in pairs where the second undoes the first
	task automatic test_buttons();
		press_buttons(8'h01, 4'h0);   // enter set-alarm
		press_buttons(8'h02, 4'h0);   // set-time locked while setting alarm
		press_buttons(8'h01, 4'h0);   // back to normal
		press_buttons(8'h02, 4'h0);   // set-time
		press_buttons(8'h01, 4'h0);   // locked while setting time
		press_buttons(8'h02, 4'h0);
		press_buttons(8'h04, 4'h0);   // alarm source radio
		press_buttons(8'h04, 4'h0);   // and back to tone
		press_buttons(8'h10, 4'h0);   // snooze with nothing playing
		press_buttons(8'h20, 4'h0);   // long snooze
		press_buttons(8'h40, 4'h0);   // radio on
		press_buttons(8'h40, 4'h0);   // radio off
		press_buttons(8'h80, 4'h0);   // twelve hour: hour 0 shown as 12
		press_buttons(8'h08, 4'h0);   // arm
		press_buttons(8'h08, 4'h0);   // disarm
		press_buttons(8'h8C, 4'h0);   // several at once, last one wins
	endtask

	// volume saturation, frequency wrap, ignored transitions
	task automatic test_knobs();
		repeat (12) turn_knob(0, 1'b1);
		repeat (17) turn_knob(0, 1'b0);
		repeat (10) turn_knob(1, 1'b0);   // wraps below the bottom of the band
		press_buttons(8'h01, 4'h0);       // locked while the frequency shows
		repeat (3) turn_knob(1, 1'b1);    // wraps back over the top
		for (int v = 0; v < 16; v++)
			send_tick(8'hFF, v[3:0]);     // arbitrary knob steps
	endtask

	// set clock and alarm: hour and minute wrap in both directions
	task automatic test_setting();
		drain_words();
		@(negedge clk);
		// wait for the frequency display to time out
		repeat (2 * TICKS_PER_SECOND) send_tick(8'hFF, 4'h0);
		press_buttons(8'h02, 4'h0);
		turn_knob(0, 1'b0);
		turn_knob(0, 1'b0);
		turn_knob(1, 1'b1);
		turn_knob(1, 1'b0);
		turn_knob(0, 1'b1);
		turn_knob(0, 1'b1);
		press_buttons(8'h02, 4'h0);
		press_buttons(8'h01, 4'h0);
		turn_knob(0, 1'b0);
		turn_knob(1, 1'b0);
		turn_knob(1, 1'b1);
		turn_knob(0, 1'b1);
		press_buttons(8'h01, 4'h0);
		press_buttons(8'h08, 4'h0);   // disarm the alarm (armed by the combined press) before the random part
	endtask

	// random ticks: mostly well-formed presses, some glitches and knob noise
	task automatic test_random();
		logic [7:0] lv;
		logic [3:0] kn;
		int run_left [8];
		bit level [8];
		lv = 8'hFF;
		kn = '0;
		foreach (run_left[i]) begin
			run_left[i] = $urandom_range(40, 1);
			level[i] = 1'b1;
		end
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			quiet = (n >= 600 && n < 900);
			if (n == 1200) begin
				drain_words();
				@(negedge clk);
			end
			for (int i = 0; i < 8; i++) begin
				if (--run_left[i] <= 0) begin
					level[i] = !level[i];
					// low runs mostly long enough to register; arming is rare
					if (level[i])
						run_left[i] = (i == 3) ? $urandom_range(600, 200) : $urandom_range(60, 1);
					else
						run_left[i] = $urandom_range(20, 8);
				end
				lv[i] = level[i];
				if ($urandom_range(99) < 3) lv[i] = !lv[i];   // glitch
			end
			if ($urandom_range(99) < 40) kn = 4'($urandom_range(15));
			send_tick(lv, kn);
		end
		quiet = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		in_valid = 1'b0;
		button_levels = 8'hFF;
		knob_bits = '0;
		out_ready = 1'b1;
		arst_n = 1'b0;
		model_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_buttons();
		test_knobs();
		test_setting();
		test_random();

		drain_words();
		// let any late word show up
		repeat (20) @(posedge clk);

		$display("sent %0d ticks, checked %0d words", ticks_sent, words_checked);
		$display("%0d ticks carried a status message, %0d with the alarm sounding",
			presses_seen, alarms_seen);
		if (errors == 0 && pending_words.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/acc_pkg.sv
rtl/acc_debounce.sv
rtl/acc_display.sv
rtl/alarm_clock_controller.sv
bench/tb_top.sv
